@@ hdl/ifpm_pkg.sv @@
package ifpm_pkg;

    localparam int CFG_ADDR_BITS = 5;

    localparam logic [1:0] MODE_AWAKE    = 2'd0;
    localparam logic [1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [1:0] MODE_ASLEEP   = 2'd2;
    localparam logic [1:0] MODE_FADE_IN  = 2'd3;

    localparam logic [23:0] RST_IDLE_TIMEOUT  = 24'd10000;
    localparam logic [7:0]  RST_FADE_OUT_STEP = 8'd8;
    localparam logic [7:0]  RST_FADE_IN_STEP  = 8'd12;
    localparam logic [7:0]  RST_FADE_OUT_INTV = 8'd20;
    localparam logic [7:0]  RST_FADE_IN_INTV  = 8'd10;
    localparam logic [7:0]  RST_TARGET        = 8'd200;

    typedef struct packed {
        logic [23:0] idle_limit;
        logic [7:0]  dim_step;
        logic [7:0]  rise_step;
        logic [7:0]  dim_period;
        logic [7:0]  rise_period;
        logic [7:0]  full_level;
    } cfg_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [1:0] power_mode;
        logic       display_asleep;
        logic       brightness_changed;
    } result_t;

endpackage

@@ hdl/ifpm_regs.sv @@
module ifpm_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ifpm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output ifpm_pkg::cfg_t                     cfg
);
    import ifpm_pkg::*;

    localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_FADE_OUT_STEP = 3'd1;
    localparam logic [2:0] REG_FADE_IN_STEP  = 3'd2;
    localparam logic [2:0] REG_FADE_OUT_INTV = 3'd3;
    localparam logic [2:0] REG_FADE_IN_INTV  = 3'd4;
    localparam logic [2:0] REG_TARGET        = 3'd5;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_IDLE_TIMEOUT:  cfg_next.idle_limit  = pwdata[23:0];
                REG_FADE_OUT_STEP: cfg_next.dim_step    = pwdata[7:0];
                REG_FADE_IN_STEP:  cfg_next.rise_step   = pwdata[7:0];
                REG_FADE_OUT_INTV: cfg_next.dim_period  = pwdata[7:0];
                REG_FADE_IN_INTV:  cfg_next.rise_period = pwdata[7:0];
                REG_TARGET:        cfg_next.full_level  = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IDLE_TIMEOUT:  prdata = {8'd0, cfg_reg.idle_limit};
            REG_FADE_OUT_STEP: prdata = {24'd0, cfg_reg.dim_step};
            REG_FADE_IN_STEP:  prdata = {24'd0, cfg_reg.rise_step};
            REG_FADE_OUT_INTV: prdata = {24'd0, cfg_reg.dim_period};
            REG_FADE_IN_INTV:  prdata = {24'd0, cfg_reg.rise_period};
            REG_TARGET:        prdata = {24'd0, cfg_reg.full_level};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit  <= RST_IDLE_TIMEOUT;
            cfg_reg.dim_step    <= RST_FADE_OUT_STEP;
            cfg_reg.rise_step   <= RST_FADE_IN_STEP;
            cfg_reg.dim_period  <= RST_FADE_OUT_INTV;
            cfg_reg.rise_period <= RST_FADE_IN_INTV;
            cfg_reg.full_level  <= RST_TARGET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/ifpm_core.sv @@
module ifpm_core #(
    parameter int IDLE_COUNT_BITS = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              activity,
    input  ifpm_pkg::cfg_t    cfg,
    output ifpm_pkg::result_t res_next
);
    import ifpm_pkg::*;

    localparam int CMP_W = (IDLE_COUNT_BITS > 24) ? IDLE_COUNT_BITS : 24;
    localparam logic [8:0] STEP_MAX = 9'd511;

    typedef enum logic [1:0] {
        ST_AWAKE    = MODE_AWAKE,
        ST_FADE_OUT = MODE_FADE_OUT,
        ST_ASLEEP   = MODE_ASLEEP,
        ST_FADE_IN  = MODE_FADE_IN
    } mode_t;

    mode_t                      mode_reg;
    mode_t                      mode_next;
    mode_t                      mode_mid;
    logic [7:0]                 level_reg;
    logic [7:0]                 level_next;
    logic [7:0]                 level_mid;
    logic [IDLE_COUNT_BITS-1:0] idle_count_reg;
    logic [IDLE_COUNT_BITS-1:0] idle_count_next;
    logic [8:0]                 step_count_reg;
    logic [8:0]                 step_count_next;
    logic [8:0]                 step_mid;
    logic [8:0]                 up_sum;
    logic                       changed;

    always_comb
    begin
        changed         = 1'b0;
        idle_count_next = (idle_count_reg == '1) ? idle_count_reg
                                                 : idle_count_reg + 1'b1;
        step_mid        = (step_count_reg == STEP_MAX) ? step_count_reg
                                                       : step_count_reg + 1'b1;
        mode_mid        = mode_reg;
        level_mid       = level_reg;

        if (activity)
        begin
            idle_count_next = '0;
            if (mode_reg == ST_FADE_OUT)
            begin
                mode_mid = ST_FADE_IN;
                step_mid = '0;
            end
            else if (mode_reg == ST_ASLEEP)
            begin
                level_mid = '0;
                changed   = 1'b1;
                mode_mid  = ST_FADE_IN;
                step_mid  = '0;
            end
        end

        mode_next       = mode_mid;
        level_next      = level_mid;
        step_count_next = step_mid;
        up_sum          = {1'b0, level_mid} + {1'b0, cfg.rise_step};

        case (mode_mid)
            ST_AWAKE:
            begin
                if (CMP_W'(idle_count_next) > CMP_W'(cfg.idle_limit))
                begin
                    mode_next       = ST_FADE_OUT;
                    step_count_next = '0;
                end
            end
            ST_FADE_OUT:
            begin
                if (step_mid > {1'b0, cfg.dim_period})
                begin
                    if (level_mid != '0)
                    begin
                        level_next = (level_mid > cfg.dim_step)
                                   ? level_mid - cfg.dim_step : '0;
                        changed    = 1'b1;
                    end
                    else
                    begin
                        mode_next = ST_ASLEEP;
                    end
                    step_count_next = '0;
                end
            end
            ST_FADE_IN:
            begin
                if (step_mid > {1'b0, cfg.rise_period})
                begin
                    if (level_mid < cfg.full_level)
                    begin
                        level_next = (up_sum > {1'b0, cfg.full_level})
                                   ? cfg.full_level : up_sum[7:0];
                        changed    = 1'b1;
                    end
                    else
                    begin
                        mode_next = ST_AWAKE;
                    end
                    step_count_next = '0;
                end
            end
            default:
            begin
                mode_next = mode_mid;
            end
        endcase

        res_next.brightness         = level_next;
        res_next.power_mode         = mode_next;
        res_next.display_asleep     = (mode_next == ST_ASLEEP);
        res_next.brightness_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_AWAKE;
            level_reg      <= RST_TARGET;
            idle_count_reg <= '0;
            step_count_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            level_reg      <= level_next;
            idle_count_reg <= idle_count_next;
            step_count_reg <= step_count_next;
        end
    end

endmodule

@@ hdl/idle_fade_power_manager.sv @@
// Chan | Dir | Handshake            | Payload
// in   | in  | in_valid, in_stall   | activity
// out  | out | out_valid, out_stall | brightness, power_mode, display_asleep, brightness_changed
// cfg  | in  | APB psel, penable    | paddr, pwdata, prdata
//
// One tick beat per cycle unless out_stall holds a full output register; a taken beat's
// result is registered when it leaves the input register. Input register, then tick logic
// into the output register; state moves on the cycle a beat leaves the input register.
// Reset: config registers at defaults, awake, level 200, counters cleared.
// in_stall is high only while the input register and output register both hold beats
// and out_stall is high.
module idle_fade_power_manager #(
    parameter int IDLE_COUNT_BITS = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               activity,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         brightness,
    output logic [1:0]                         power_mode,
    output logic                               display_asleep,
    output logic                               brightness_changed,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ifpm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ifpm_pkg::*;

    cfg_t    cfg;
    result_t res_next;
    result_t res_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s1_activity_reg;
    logic    out_valid_reg;
    logic    out_open;
    logic    s1_fire;
    logic    accept;

    assign out_open = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_open;
    assign in_stall = s1_valid_reg && !out_open;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_fire);

    ifpm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifpm_core #(
        .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (s1_fire),
        .activity (s1_activity_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_open)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_activity_reg <= activity;
        end
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign brightness         = res_reg.brightness;
    assign power_mode         = res_reg.power_mode;
    assign display_asleep     = res_reg.display_asleep;
    assign brightness_changed = res_reg.brightness_changed;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled with room downstream");

    a_beat_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("beat left input register but no output beat");

    a_asleep_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (display_asleep == (power_mode == MODE_ASLEEP)))
        else $error("asleep flag disagrees with mode");

    a_change_only_ramping: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && brightness_changed)
            |-> (power_mode == MODE_FADE_OUT || power_mode == MODE_FADE_IN))
        else $error("brightness changed outside a ramp");

endmodule
